// File: hdl/ppt_pkg.sv
`default_nettype none
package ppt_pkg;

  // CORDIC depth; the angle table holds 32 entries, so deeper settings stop there
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 32;
  localparam int NUM_STAGES    = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
  localparam int STAGE_W       = $clog2(ATAN_ENTRIES);

  // Datapath widths: operand after pose subtraction, prescaled rotator word, angle residual
  localparam int OP_W   = 33;
  localparam int PROD_W = 64;
  localparam int XW     = 44;
  localparam int ZW     = 34;
  localparam int RND_W  = XW - 8;
  localparam int SUM_W  = 38;

  // 1/K of the rotator in Q0.30
  localparam logic [30:0] INV_GAIN = 31'd652032874;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_POSE_X  = 2'd0;
  localparam logic [1:0] REG_POSE_Y  = 2'd1;
  localparam logic [1:0] REG_HEADING = 2'd2;

  // Command codes
  localparam logic CMD_BODY_TO_WORLD = 1'b0;
  localparam logic CMD_WORLD_TO_BODY = 1'b1;

  typedef struct packed {
    logic               command;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic        [15:0] heading;
  } pose_t;

  // One beat travelling down the rotator chain
  typedef struct packed {
    logic                valid;
    logic                command;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cell_t;

  // Arctangent of 2^-i as a 32-bit binary angle
  function automatic logic [31:0] atan_of(input logic [STAGE_W-1:0] i);
    logic [31:0] a;
    case (i)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      5'd24:   a = 32'h00000029;
      5'd25:   a = 32'h00000014;
      5'd26:   a = 32'h0000000A;
      5'd27:   a = 32'h00000005;
      5'd28:   a = 32'h00000003;
      5'd29:   a = 32'h00000001;
      5'd30:   a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// File: hdl/ppt_prep.sv
`default_nettype none
module ppt_prep (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire ppt_pkg::in_t    request,
  input  wire ppt_pkg::pose_t  pose,
  output ppt_pkg::cell_t       head
);

  // Stage one: operands and rotation angle
  logic                            s1_valid;
  logic                            s1_command;
  logic signed [ppt_pkg::OP_W-1:0] s1_u;
  logic signed [ppt_pkg::OP_W-1:0] s1_v;
  logic        [15:0]              s1_ang;

  // Stage two: gain-compensated products
  logic                              s2_valid;
  logic                              s2_command;
  logic signed [ppt_pkg::PROD_W-1:0] s2_pu;
  logic signed [ppt_pkg::PROD_W-1:0] s2_pv;
  logic        [15:0]                s2_ang;

  logic signed [ppt_pkg::OP_W-1:0]   u_next;
  logic signed [ppt_pkg::OP_W-1:0]   v_next;
  logic        [15:0]                ang_next;
  logic signed [ppt_pkg::PROD_W-1:0] ru;
  logic signed [ppt_pkg::PROD_W-1:0] rv;
  logic signed [ppt_pkg::XW-1:0]     xs;
  logic signed [ppt_pkg::XW-1:0]     ys;
  logic                              flip;
  logic        [31:0]                a32;
  ppt_pkg::cell_t                    head_next;

  // Form operands: subtract the pose and negate the heading for world to body
  always_comb begin
    if (request.command == ppt_pkg::CMD_WORLD_TO_BODY) begin
      u_next   = ppt_pkg::OP_W'(request.point_x) - ppt_pkg::OP_W'(pose.pose_x);
      v_next   = ppt_pkg::OP_W'(request.point_y) - ppt_pkg::OP_W'(pose.pose_y);
      ang_next = 16'(16'd0 - pose.heading);
    end else begin
      u_next   = ppt_pkg::OP_W'(request.point_x);
      v_next   = ppt_pkg::OP_W'(request.point_y);
      ang_next = pose.heading;
    end
  end

  always_ff @(posedge clk) begin
    s1_u       <= u_next;
    s1_v       <= v_next;
    s1_ang     <= ang_next;
    s1_command <= request.command;
    s2_pu      <= ppt_pkg::PROD_W'(s1_u * $signed({1'b0, ppt_pkg::INV_GAIN}));
    s2_pv      <= ppt_pkg::PROD_W'(s1_v * $signed({1'b0, ppt_pkg::INV_GAIN}));
    s2_ang     <= s1_ang;
    s2_command <= s1_command;
    head.command <= head_next.command;
    head.x       <= head_next.x;
    head.y       <= head_next.y;
    head.z       <= head_next.z;
  end

  // Advance the valid marks
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      head.valid <= 1'b0;
    end else begin
      s1_valid   <= start;
      s2_valid   <= s1_valid;
      head.valid <= head_next.valid;
    end
  end

  // Round to Q.24 and fold the angle into the right half plane
  always_comb begin
    ru   = s2_pu + ppt_pkg::PROD_W'(64'sd2097152);
    rv   = s2_pv + ppt_pkg::PROD_W'(64'sd2097152);
    xs   = ppt_pkg::XW'($signed(ru[ppt_pkg::PROD_W-1:22]));
    ys   = ppt_pkg::XW'($signed(rv[ppt_pkg::PROD_W-1:22]));
    flip = s2_ang[15] ^ s2_ang[14];
    a32  = {s2_ang[15] ^ flip, s2_ang[14:0], 16'd0};
    head_next.valid   = s2_valid;
    head_next.command = s2_command;
    head_next.x       = flip ? -xs : xs;
    head_next.y       = flip ? -ys : ys;
    head_next.z       = ppt_pkg::ZW'($signed(a32));
  end

endmodule
`default_nettype wire

// File: hdl/ppt_cell.sv
`default_nettype none
module ppt_cell (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic [ppt_pkg::STAGE_W-1:0]        stage,
  input  wire ppt_pkg::cell_t                     din,
  output ppt_pkg::cell_t                          dout
);

  logic signed [ppt_pkg::XW-1:0] dx;
  logic signed [ppt_pkg::XW-1:0] dy;
  logic signed [ppt_pkg::ZW-1:0] da;
  ppt_pkg::cell_t                dout_next;

  // Rotate one micro-step toward zero residual angle
  always_comb begin
    dx = din.y >>> stage;
    dy = din.x >>> stage;
    da = ppt_pkg::ZW'(ppt_pkg::atan_of(stage));
    dout_next.valid   = din.valid;
    dout_next.command = din.command;
    if (!din.z[ppt_pkg::ZW-1]) begin
      dout_next.x = din.x - dx;
      dout_next.y = din.y + dy;
      dout_next.z = din.z - da;
    end else begin
      dout_next.x = din.x + dx;
      dout_next.y = din.y - dy;
      dout_next.z = din.z + da;
    end
  end

  always_ff @(posedge clk) begin
    dout.command <= dout_next.command;
    dout.x       <= dout_next.x;
    dout.y       <= dout_next.y;
    dout.z       <= dout_next.z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= dout_next.valid;
    end
  end

endmodule
`default_nettype wire

// File: hdl/ppt_post.sv
`default_nettype none
module ppt_post (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ppt_pkg::cell_t  tail,
  input  wire ppt_pkg::pose_t  pose,
  output logic                 done,
  output ppt_pkg::out_t        result
);

  logic signed [ppt_pkg::XW-1:0]    xr;
  logic signed [ppt_pkg::XW-1:0]    yr;
  logic signed [ppt_pkg::SUM_W-1:0] sx;
  logic signed [ppt_pkg::SUM_W-1:0] sy;
  logic                             ovx;
  logic                             ovy;
  ppt_pkg::out_t                    result_next;

  // Clamp a wide sum to signed 32 bits
  function automatic logic [31:0] clamp32(input logic signed [ppt_pkg::SUM_W-1:0] s,
                                          input logic ov);
    logic [31:0] r;
    if (!ov) begin
      r = s[31:0];
    end else if (s[ppt_pkg::SUM_W-1]) begin
      r = 32'h80000000;
    end else begin
      r = 32'h7FFFFFFF;
    end
    return r;
  endfunction

  // Round to Q16.16, add the pose for body to world, then saturate
  always_comb begin
    xr = tail.x + ppt_pkg::XW'(128);
    yr = tail.y + ppt_pkg::XW'(128);
    sx = ppt_pkg::SUM_W'($signed(xr[ppt_pkg::XW-1:8]));
    sy = ppt_pkg::SUM_W'($signed(yr[ppt_pkg::XW-1:8]));
    if (tail.command == ppt_pkg::CMD_BODY_TO_WORLD) begin
      sx = sx + ppt_pkg::SUM_W'(pose.pose_x);
      sy = sy + ppt_pkg::SUM_W'(pose.pose_y);
    end
    ovx = (sx[ppt_pkg::SUM_W-1:31] != {(ppt_pkg::SUM_W-31){sx[31]}});
    ovy = (sy[ppt_pkg::SUM_W-1:31] != {(ppt_pkg::SUM_W-31){sy[31]}});
    result_next.out_x     = clamp32(sx, ovx);
    result_next.out_y     = clamp32(sy, ovy);
    result_next.saturated = ovx | ovy;
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tail.valid;
    end
  end

endmodule
`default_nettype wire

// File: hdl/planar_pose_transform.sv
`default_nettype none
// Planar pose transform: moves a Q16.16 point between the robot body frame and
// the world frame using the pose held in three registers (pose_x, pose_y,
// heading). A point is taken at every clock edge with start high and busy
// low; busy is high only during reset, so one point per clock streams
// through. Each point passes the operand, multiply and prescale stages, one
// rotator cell per CORDIC stage and the output round-and-clamp stage. Each
// result is shown on result for one cycle with done high; the receiver cannot
// hold it off and must take it then. Write the pose only while no points are
// in flight.
module planar_pose_transform (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire ppt_pkg::in_t       request,
  output logic                    done,
  output ppt_pkg::out_t           result,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  ppt_pkg::pose_t pose;
  ppt_pkg::cell_t chain [ppt_pkg::NUM_STAGES+1];

  assign busy = rst;

  // Hold the pose registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pose.pose_x  <= '0;
      pose.pose_y  <= '0;
      pose.heading <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        ppt_pkg::REG_POSE_X:  pose.pose_x  <= cfg_data;
        ppt_pkg::REG_POSE_Y:  pose.pose_y  <= cfg_data;
        ppt_pkg::REG_HEADING: pose.heading <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  ppt_prep u_prep (
    .clk     (clk),
    .rst     (rst),
    .start   (start & ~busy),
    .request (request),
    .pose    (pose),
    .head    (chain[0])
  );

  // Rotator chain, one cell per micro-rotation
  for (genvar i = 0; i < ppt_pkg::NUM_STAGES; i++) begin : g_cell
    ppt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .stage (ppt_pkg::STAGE_W'(i)),
      .din   (chain[i]),
      .dout  (chain[i+1])
    );
  end

  ppt_post u_post (
    .clk    (clk),
    .rst    (rst),
    .tail   (chain[ppt_pkg::NUM_STAGES]),
    .pose   (pose),
    .done   (done),
    .result (result)
  );

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

// Tracks the pose registers and predicts each transformed point; checks results in order
class frame_transform_check;
  ppt_pkg::out_t awaited_points[$];
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic [15:0] heading;
  longint angle_step[32];
  int unsigned failures;

  function new();
    pose_x = '0;
    pose_y = '0;
    heading = '0;
    failures = 0;
    // atan(2^-i) as a 32-bit binary angle
    angle_step = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000};
  endfunction

  function void write_reg(input logic [1:0] index, input logic [31:0] data);
    case (index)
      ppt_pkg::REG_POSE_X: pose_x = data;
      ppt_pkg::REG_POSE_Y: pose_y = data;
      ppt_pkg::REG_HEADING: heading = data[15:0];
      default: ;
    endcase
  endfunction

  // Rotate a Q16.16 vector by a 16-bit binary angle through the fixed-point CORDIC
  function void cordic_rotate(input longint u, input longint v, input logic [15:0] ang,
                              output longint ru, output longint rv);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    logic [31:0] a;
    int n;
    int i;
    n = (ppt_pkg::CORDIC_STAGES > 32) ? 32 : ppt_pkg::CORDIC_STAGES;
    // prescale by 1/K (Q0.30) into Q.24
    x = (u * 64'sd652032874 + 64'sd2097152) >>> 22;
    y = (v * 64'sd652032874 + 64'sd2097152) >>> 22;
    a = {ang, 16'h0000};
    // fold angles outside +-90 degrees by a half turn
    if (a[31] ^ a[30]) begin
      x = -x;
      y = -y;
      a = a + 32'h80000000;
    end
    z = longint'($signed(a));
    for (i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - angle_step[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + angle_step[i];
      end
    end
    ru = (x + 128) >>> 8;
    rv = (y + 128) >>> 8;
  endfunction

  function logic [31:0] clamp_q16(input longint v, inout logic sat);
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'h7FFFFFFF;
    end
    return v[31:0];
  endfunction

  function ppt_pkg::out_t transform_point(input ppt_pkg::in_t p);
    longint px;
    longint py;
    longint rx;
    longint ry;
    logic [15:0] back_angle;
    logic sat;
    ppt_pkg::out_t r;
    px = longint'($signed(p.point_x));
    py = longint'($signed(p.point_y));
    if (p.command == ppt_pkg::CMD_BODY_TO_WORLD) begin
      cordic_rotate(px, py, heading, rx, ry);
      rx = rx + longint'($signed(pose_x));
      ry = ry + longint'($signed(pose_y));
    end else begin
      // a half turn negates onto itself
      back_angle = 16'h0000 - heading;
      cordic_rotate(px - longint'($signed(pose_x)), py - longint'($signed(pose_y)),
                    back_angle, rx, ry);
    end
    sat = 1'b0;
    r.out_x = clamp_q16(rx, sat);
    r.out_y = clamp_q16(ry, sat);
    r.saturated = sat;
    return r;
  endfunction

  function void note_point(input ppt_pkg::in_t p);
    awaited_points.push_back(transform_point(p));
  endfunction

  function void check_result(input ppt_pkg::out_t got);
    ppt_pkg::out_t want;
    if (awaited_points.size() == 0) begin
      $error("result with nothing awaited: out_x %0d out_y %0d", $signed(got.out_x),
             $signed(got.out_y));
      failures++;
      return;
    end
    want = awaited_points.pop_front();
    if (got.out_x !== want.out_x) begin
      $error("out_x: expected %0d, got %0d", $signed(want.out_x), $signed(got.out_x));
      failures++;
    end
    if (got.out_y !== want.out_y) begin
      $error("out_y: expected %0d, got %0d", $signed(want.out_y), $signed(got.out_y));
      failures++;
    end
    if (got.saturated !== want.saturated) begin
      $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
      failures++;
    end
  endfunction

  function int pending();
    return awaited_points.size();
  endfunction
endclass

module tb;
  import ppt_pkg::*;

  localparam int LATENCY = NUM_STAGES + 4;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam logic [31:0] Q_MAX32 = 32'h7FFFFFFF;
  localparam logic [31:0] Q_MIN32 = 32'h80000000;
  localparam logic [31:0] ONE = 32'h00010000;
  localparam logic [31:0] NEG_ONE = 32'hFFFF0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_t request = '0;
  logic done;
  out_t result;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  frame_transform_check xform = new();
  bit back_to_back = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  planar_pose_transform DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Take every result beat; the block cannot be held off
  always @(posedge clk) begin
    if (!rst && done) xform.check_result(result);
  end

  // Offer one point, after a random gap unless back_to_back is set, and hold it until the block takes it
  task automatic send_point(input in_t p);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= p;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    xform.note_point(p);
  endtask

  // Write all pose registers plus the unused index, back to back
  task automatic set_pose(input logic [31:0] px, input logic [31:0] py,
                          input logic [15:0] hd);
    logic [31:0] spare;
    logic [31:0] hd_word;
    spare = $urandom();
    hd_word = {spare[31:16], hd};
    cfg_write <= 1'b1;
    cfg_index <= REG_POSE_X;
    cfg_data <= px;
    @(posedge clk);
    xform.write_reg(REG_POSE_X, px);
    cfg_index <= REG_POSE_Y;
    cfg_data <= py;
    @(posedge clk);
    xform.write_reg(REG_POSE_Y, py);
    cfg_index <= REG_HEADING;
    cfg_data <= hd_word;
    @(posedge clk);
    xform.write_reg(REG_HEADING, hd_word);
    cfg_index <= REG_SPARE;
    cfg_data <= spare;
    @(posedge clk);
    xform.write_reg(REG_SPARE, spare);
    cfg_write <= 1'b0;
  endtask

  // Drop start and let the pipeline empty
  task automatic settle();
    int waited;
    start <= 1'b0;
    waited = 0;
    while (xform.pending() != 0 && waited < 50 * LATENCY) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Mix of extremes, short values, mid-range and full-range coordinates
  function automatic logic [31:0] rand_coord();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return Q_MAX32;
          1: return Q_MIN32;
          2: return 32'h0;
          default: return 32'hFFFFFFFF;
        endcase
      end
      1, 2, 3, 4: return {{10{r[21]}}, r[21:0]};
      5, 6: return {{2{r[29]}}, r[29:0]};
      default: return r;
    endcase
  endfunction

  function automatic logic [15:0] rand_heading();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'h4000;
      2: return 16'hC000;
      3: return 16'h8000;
      4: return 16'h7FFF;
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    in_t p;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Identity pose: zero, full-scale and opposite-corner points
    set_pose(32'h0, 32'h0, 16'h0000);
    send_point('{CMD_BODY_TO_WORLD, 32'h0, 32'h0});
    send_point('{CMD_BODY_TO_WORLD, Q_MAX32, Q_MAX32});
    send_point('{CMD_BODY_TO_WORLD, Q_MIN32, Q_MIN32});
    send_point('{CMD_WORLD_TO_BODY, Q_MAX32, Q_MIN32});
    send_point('{CMD_WORLD_TO_BODY, ONE, NEG_ONE});
    settle();

    // Exact quarter turn, both directions
    back_to_back = 1'b1;
    set_pose(32'h00018000, 32'hFFFDC000, 16'h4000);
    send_point('{CMD_BODY_TO_WORLD, ONE, 32'h0});
    send_point('{CMD_WORLD_TO_BODY, ONE, 32'h0});
    send_point('{CMD_BODY_TO_WORLD, 32'h0, ONE});
    send_point('{CMD_WORLD_TO_BODY, Q_MIN32, Q_MAX32});
    settle();

    // Negative quarter turn
    set_pose(NEG_ONE, ONE, 16'hC000);
    send_point('{CMD_BODY_TO_WORLD, ONE, ONE});
    send_point('{CMD_WORLD_TO_BODY, ONE, ONE});
    settle();

    // Half turn: its negation wraps onto itself
    back_to_back = 1'b0;
    set_pose(32'h00050000, 32'hFFF00000, 16'h8000);
    send_point('{CMD_WORLD_TO_BODY, ONE, 32'h00020000});
    send_point('{CMD_BODY_TO_WORLD, ONE, 32'h00020000});
    send_point('{CMD_WORLD_TO_BODY, 32'h0, 32'h0});
    settle();

    // Extreme pose: clamp on both sides
    set_pose(Q_MAX32, Q_MIN32, 16'h2000);
    send_point('{CMD_BODY_TO_WORLD, Q_MAX32, Q_MAX32});
    send_point('{CMD_BODY_TO_WORLD, Q_MIN32, Q_MIN32});
    send_point('{CMD_WORLD_TO_BODY, Q_MIN32, Q_MAX32});
    send_point('{CMD_WORLD_TO_BODY, Q_MAX32, Q_MIN32});
    send_point('{CMD_BODY_TO_WORLD, 32'hFFFFFFFF, 32'h00000001});
    settle();

    set_pose(Q_MIN32, Q_MAX32, 16'h7FFF);
    send_point('{CMD_BODY_TO_WORLD, ONE, NEG_ONE});
    send_point('{CMD_WORLD_TO_BODY, NEG_ONE, ONE});
    settle();

    // Random poses, each followed by a stream of random points
    for (int phase = 0; phase < 31; phase++) begin
      set_pose(rand_coord(), rand_coord(), rand_heading());
      for (int k = 0; k < 50; k++) begin
        if (k % 10 == 0) back_to_back = ($urandom_range(0, 3) == 0);
        p.command = 1'($urandom_range(0, 1));
        p.point_x = rand_coord();
        p.point_y = rand_coord();
        send_point(p);
      end
      settle();
    end

    if (xform.pending() != 0) $error("%0d results never arrived", xform.pending());
    if (xform.failures == 0 && xform.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

// File: planar_pose_transform.f
hdl/ppt_pkg.sv
hdl/ppt_prep.sv
hdl/ppt_cell.sv
hdl/ppt_post.sv
hdl/planar_pose_transform.sv
tb/sv/tb.sv
